// ===== sv/pti_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pti_pkg
// Shared constants, state and select codes, and controller/datapath structs
// for the packet timestamp interpolator.
// ============================================================================
package pti_pkg;

    // Block constants
    localparam int unsigned CALIBRATION_PERIOD = 64;
    localparam int unsigned UNITS_PER_SECOND   = 10000000;
    localparam int unsigned EXTRA_BYTES        = 24;

    // Field and state widths
    localparam int TICK_W  = 34;
    localparam int TIME_W  = 64;
    localparam int LEN_W   = 16;
    localparam int CNT_W   = 16;
    localparam int BYTE_W  = 32;
    localparam int SPEED_W = 32;
    localparam int HALF_W  = 32;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 32'd1250;
    localparam logic [TICK_W-1:0]  TICK_RESET  = 34'd1000000000;

    // Cycle-to-time conversion: diff (64b) * UNITS_PER_SECOND, done as two halves
    localparam int UPS_W  = $clog2(UNITS_PER_SECOND + 1);
    localparam int MUL_W  = HALF_W + UPS_W;
    localparam int PROD_W = TIME_W + UPS_W;

    // Divider step counts
    localparam int STEP_W = $clog2(PROD_W + 1);
    localparam logic [STEP_W-1:0] STEPS_WIDE   = STEP_W'(PROD_W);
    localparam logic [STEP_W-1:0] STEPS_NARROW = STEP_W'(BYTE_W);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_CYCLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_TIME   = 2'd2;

    // Divider operand select
    typedef enum logic [1:0] {
        DIV_EST,
        DIV_TRUE,
        DIV_SPEED,
        DIV_OUT
    } div_sel_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_EST_GO,
        S_EST_WAIT,
        S_MUL_LO,
        S_MUL_HI,
        S_TT_GO,
        S_TT_WAIT,
        S_UPDATE,
        S_EL_CHECK,
        S_EL_GO,
        S_EL_WAIT,
        S_ACC,
        S_OUT_GO,
        S_OUT_WAIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic     capture;
        logic     div_start;
        div_sel_t div_sel;
        logic     est_load;
        logic     mul_lo;
        logic     mul_hi;
        logic     now_load;
        logic     update;
        logic     speed_load;
        logic     acc;
        logic     out_load;
    } pti_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cal;
        logic div_busy;
        logic elapsed_zero;
    } pti_status_t;

endpackage

// ===== sv/pti_divider.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pti_divider
// Shared restoring divider, one quotient bit per cycle. The dividend is
// left-aligned; the step count says how many of its top bits are consumed.
// ============================================================================
module pti_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pti_pkg::PROD_W-1:0]  dividend,
    input  logic [pti_pkg::TIME_W-1:0]  divisor,
    input  logic [pti_pkg::STEP_W-1:0]  steps,
    output logic                        busy,
    output logic [pti_pkg::TIME_W-1:0]  quotient
);
    import pti_pkg::*;

    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic [PROD_W-1:0] num_reg;
    logic [PROD_W-1:0] num_next;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] rem_next;
    logic [TIME_W-1:0] quot_reg;
    logic [TIME_W-1:0] quot_next;
    logic [TIME_W-1:0] div_reg;
    logic [TIME_W-1:0] div_next;
    logic [TIME_W:0]   rem_shift;
    logic [TIME_W:0]   rem_diff;
    logic              ge;

    // One restoring step: shift in next dividend bit, try subtract
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[PROD_W-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        ge        = (rem_shift >= {1'b0, div_reg});
    end

    // Next state of the iteration
    always_comb
    begin
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        div_next  = div_reg;
        if (start)
        begin
            cnt_next  = steps;
            num_next  = dividend;
            rem_next  = '0;
            quot_next = '0;
            div_next  = divisor;
        end
        else if (busy)
        begin
            cnt_next  = cnt_reg - 1'b1;
            num_next  = {num_reg[PROD_W-2:0], 1'b0};
            rem_next  = ge ? rem_diff[TIME_W-1:0] : rem_shift[TIME_W-1:0];
            quot_next = {quot_reg[TIME_W-2:0], ge};
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        div_reg  <= div_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quot_reg;

endmodule

// ===== sv/pti_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pti_datapath
// Configuration registers, interpolation state, cycle-to-time multiplier,
// shared divider and the output register.
// ============================================================================
module pti_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  pti_pkg::pti_cmd_t               cmd,
    output pti_pkg::pti_status_t            status,
    input  logic                            cfg_write,
    input  logic [pti_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pti_pkg::TIME_W-1:0]      cfg_data,
    input  logic [pti_pkg::LEN_W-1:0]       packet_length,
    input  logic [pti_pkg::TIME_W-1:0]      cycle_count,
    output logic [pti_pkg::TIME_W-1:0]      timestamp,
    output logic                            recalibrated
);
    import pti_pkg::*;

    // Configuration
    logic [TICK_W-1:0]  tick_rate_reg;
    logic [TIME_W-1:0]  base_cycles_reg;
    logic [TIME_W-1:0]  base_time_reg;

    // Interpolation state
    logic [CNT_W-1:0]   item_counter_reg;
    logic [TIME_W-1:0]  anchor_reg;
    logic [BYTE_W-1:0]  byte_total_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic               cal_reg;

    logic [CNT_W-1:0]   item_counter_next;
    logic [TIME_W-1:0]  anchor_next;
    logic [BYTE_W-1:0]  byte_total_next;
    logic [SPEED_W-1:0] speed_next;
    logic               cal_next;

    // Per-item working registers
    logic [LEN_W-1:0]   len_reg;
    logic [TIME_W-1:0]  diff_reg;
    logic [MUL_W-1:0]   prod_lo_reg;
    logic [MUL_W-1:0]   prod_hi_reg;
    logic [TIME_W-1:0]  est_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  elapsed_reg;
    logic [TIME_W-1:0]  ts_reg;
    logic               recal_reg;

    // Divider interface
    logic [PROD_W-1:0]  div_dividend;
    logic [TIME_W-1:0]  div_divisor;
    logic [STEP_W-1:0]  div_steps;
    logic               div_busy;
    logic [TIME_W-1:0]  div_quot;

    logic [BYTE_W-1:0]  acc_base;
    logic [BYTE_W:0]    acc_sum;
    logic               is_cal;

    pti_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Divider operand select
    always_comb
    begin
        case (cmd.div_sel) inside
            DIV_TRUE:
            begin
                div_dividend = {prod_hi_reg, {HALF_W{1'b0}}} + PROD_W'(prod_lo_reg);
                div_divisor  = TIME_W'(tick_rate_reg);
                div_steps    = STEPS_WIDE;
            end
            DIV_SPEED:
            begin
                div_dividend = {byte_total_reg, {(PROD_W-BYTE_W){1'b0}}};
                div_divisor  = elapsed_reg;
                div_steps    = STEPS_NARROW;
            end
            DIV_EST, DIV_OUT:
            begin
                div_dividend = {byte_total_reg, {(PROD_W-BYTE_W){1'b0}}};
                div_divisor  = TIME_W'(speed_reg);
                div_steps    = STEPS_NARROW;
            end
            default:
            begin
                div_dividend = {byte_total_reg, {(PROD_W-BYTE_W){1'b0}}};
                div_divisor  = TIME_W'(speed_reg);
                div_steps    = STEPS_NARROW;
            end
        endcase
    end

    // Byte accumulation, saturating; cleared first on a calibrating item
    always_comb
    begin
        acc_base = cal_reg ? '0 : byte_total_reg;
        acc_sum  = {1'b0, acc_base} + (BYTE_W+1)'(len_reg)
                   + (BYTE_W+1)'(EXTRA_BYTES);
    end

    assign is_cal = (item_counter_reg == CNT_W'(CALIBRATION_PERIOD));

    // Next values of the interpolation state
    always_comb
    begin
        item_counter_next = item_counter_reg;
        cal_next          = cal_reg;
        anchor_next       = anchor_reg;
        byte_total_next   = byte_total_reg;
        speed_next        = speed_reg;

        if (cmd.capture)
        begin
            cal_next          = is_cal;
            item_counter_next = is_cal ? CNT_W'(1) : item_counter_reg + 1'b1;
        end
        if (cfg_write && (cfg_index == REG_BASE_TIME))
        begin
            anchor_next = cfg_data;
        end
        else if (cmd.update && (est_reg < now_reg))
        begin
            anchor_next = now_reg;
        end
        if (cmd.speed_load)
        begin
            speed_next = (div_quot == '0) ? SPEED_W'(1) : div_quot[SPEED_W-1:0];
        end
        if (cmd.acc)
        begin
            byte_total_next = acc_sum[BYTE_W] ? '1 : acc_sum[BYTE_W-1:0];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg   <= TICK_RESET;
            base_cycles_reg <= '0;
            base_time_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TICK_RATE:   tick_rate_reg   <= cfg_data[TICK_W-1:0];
                REG_BASE_CYCLES: base_cycles_reg <= cfg_data;
                REG_BASE_TIME:   base_time_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Interpolation state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_counter_reg <= '0;
            cal_reg          <= 1'b0;
            anchor_reg       <= '0;
            byte_total_reg   <= '0;
            speed_reg        <= SPEED_RESET;
        end
        else
        begin
            item_counter_reg <= item_counter_next;
            cal_reg          <= cal_next;
            anchor_reg       <= anchor_next;
            byte_total_reg   <= byte_total_next;
            speed_reg        <= speed_next;
        end
    end

    // Per-item working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            len_reg  <= packet_length;
            diff_reg <= cycle_count - base_cycles_reg;
        end
        if (cmd.est_load)
        begin
            est_reg <= anchor_reg + div_quot;
        end
        if (cmd.mul_lo)
        begin
            prod_lo_reg <= MUL_W'(diff_reg[HALF_W-1:0]) * MUL_W'(UNITS_PER_SECOND);
        end
        if (cmd.mul_hi)
        begin
            prod_hi_reg <= MUL_W'(diff_reg[TIME_W-1:HALF_W]) * MUL_W'(UNITS_PER_SECOND);
        end
        if (cmd.now_load)
        begin
            now_reg <= div_quot + base_time_reg;
        end
        if (cmd.update)
        begin
            elapsed_reg <= now_reg - anchor_reg;
        end
        if (cmd.out_load)
        begin
            ts_reg    <= anchor_reg + div_quot;
            recal_reg <= cal_reg;
        end
    end

    assign status.cal          = cal_reg;
    assign status.div_busy     = div_busy;
    assign status.elapsed_zero = (elapsed_reg == '0);

    assign timestamp    = ts_reg;
    assign recalibrated = recal_reg;

endmodule

// ===== sv/pti_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pti_ctrl
// Sequencer for one item: optional calibration, byte accumulation, output
// division; owns the input and output handshakes.
// ============================================================================
module pti_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  pti_pkg::pti_status_t  status,
    output pti_pkg::pti_cmd_t     cmd
);
    import pti_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_DECIDE;
            S_DECIDE:   state_next = status.cal ? S_EST_GO : S_ACC;
            S_EST_GO:   state_next = S_EST_WAIT;
            S_EST_WAIT: if (!status.div_busy) state_next = S_MUL_LO;
            S_MUL_LO:   state_next = S_MUL_HI;
            S_MUL_HI:   state_next = S_TT_GO;
            S_TT_GO:    state_next = S_TT_WAIT;
            S_TT_WAIT:  if (!status.div_busy) state_next = S_UPDATE;
            S_UPDATE:   state_next = S_EL_CHECK;
            S_EL_CHECK: state_next = status.elapsed_zero ? S_ACC : S_EL_GO;
            S_EL_GO:    state_next = S_EL_WAIT;
            S_EL_WAIT:  if (!status.div_busy) state_next = S_ACC;
            S_ACC:      state_next = S_OUT_GO;
            S_OUT_GO:   state_next = S_OUT_WAIT;
            S_OUT_WAIT: if (!status.div_busy && out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = DIV_EST;
        unique case (state_reg)
            S_IDLE:     cmd.capture = in_valid;
            S_DECIDE:   ;
            S_EST_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_EST;
            end
            S_EST_WAIT: cmd.est_load = !status.div_busy;
            S_MUL_LO:   cmd.mul_lo = 1'b1;
            S_MUL_HI:   cmd.mul_hi = 1'b1;
            S_TT_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TRUE;
            end
            S_TT_WAIT:  cmd.now_load = !status.div_busy;
            S_UPDATE:   cmd.update = 1'b1;
            S_EL_CHECK: ;
            S_EL_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SPEED;
            end
            S_EL_WAIT:  cmd.speed_load = !status.div_busy;
            S_ACC:      cmd.acc = 1'b1;
            S_OUT_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_OUT;
            end
            S_OUT_WAIT: cmd.out_load = !status.div_busy && out_free;
            default:    ;
        endcase
    end

    // Output valid: set on load, cleared when the item is taken
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== sv/packet_timestamp_interpolator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// packet_timestamp_interpolator
// Estimates packet arrival times from accumulated bytes and a learned link
// speed, recalibrating against the cycle counter at a fixed item interval.
// ============================================================================
// One item is in work at a time. An ordinary item's result comes from the
// 32-step division of the byte total by the speed in the shared radix-2
// divider. One item in every 64 also recalibrates: a 32-step estimate
// division, two 32x24 partial products, an 88-step division of the scaled
// cycle difference by the tick rate and, unless no time has elapsed, a
// 32-step speed division, all on the same divider. A new item is taken as
// soon as the previous result sits in the output register; configuration
// is accepted every cycle and belongs in idle time.
module packet_timestamp_interpolator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pti_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pti_pkg::TIME_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pti_pkg::LEN_W-1:0]       packet_length,
    input  logic [pti_pkg::TIME_W-1:0]      cycle_count,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pti_pkg::TIME_W-1:0]      timestamp,
    output logic                            recalibrated
);
    import pti_pkg::*;

    pti_cmd_t    cmd;
    pti_status_t status;
    logic        cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    pti_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pti_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .packet_length (packet_length),
        .cycle_count   (cycle_count),
        .timestamp     (timestamp),
        .recalibrated  (recalibrated)
    );

endmodule

// ===== tb/packet_timestamp_interpolator_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// packet_timestamp_interpolator_tb
// Self-checking bench for the timestamp interpolator. A behavioral predictor
// tracks the anchor, byte total, learned speed and item count, and computes
// the expected timestamp for every accepted item. Tests cover field extremes,
// several tick-rate and base settings, steered calibrations (zero, tiny and
// negative elapsed time), zero tick rate, and random handshake pressure.
// ============================================================================
module packet_timestamp_interpolator_tb;

    import pti_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam int SUM_W          = BYTE_W + 1;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 250;

    typedef struct {
        logic [TIME_W-1:0] stamp;
        logic              recal;
    } arrival_t;

    typedef enum {
        STYLE_STREAM,
        STYLE_STEER,
        STYLE_WILD
    } cyc_style_t;

    // DUT connections
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [TIME_W-1:0]    cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [LEN_W-1:0]     packet_length = '0;
    logic [TIME_W-1:0]    cycle_count   = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [TIME_W-1:0]    timestamp;
    logic                 recalibrated;

    // Predictor state and register copies
    logic [TICK_W-1:0]  pred_tick_rate;
    logic [TIME_W-1:0]  pred_base_cycles;
    logic [TIME_W-1:0]  pred_base_time;
    logic [CNT_W-1:0]   pred_items;
    logic [TIME_W-1:0]  pred_anchor;
    logic [BYTE_W-1:0]  pred_bytes;
    logic [SPEED_W-1:0] pred_speed;

    arrival_t          pending_stamps[$];
    logic [TIME_W-1:0] stream_cycles = '0;
    int                errors        = 0;
    int                stalled       = 0;
    bit                tx_random     = 1'b0;
    bit                rx_random     = 1'b0;
    int                rx_hold       = 0;

    packet_timestamp_interpolator uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .packet_length (packet_length),
        .cycle_count   (cycle_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .timestamp     (timestamp),
        .recalibrated  (recalibrated)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic reset_model();
        pred_tick_rate   = TICK_RESET;
        pred_base_cycles = '0;
        pred_base_time   = '0;
        pred_items       = '0;
        pred_anchor      = '0;
        pred_bytes       = '0;
        pred_speed       = SPEED_RESET;
    endtask

    // Cycle count to wall time; the product is kept at full width
    function automatic logic [TIME_W-1:0] wall_time(input logic [TIME_W-1:0] cyc);
        logic [TIME_W-1:0] diff;
        logic [127:0]      prod;
        diff = cyc - pred_base_cycles;
        if (pred_tick_rate == '0)
            return '1 + pred_base_time;
        prod = 128'(diff) * 128'(UNITS_PER_SECOND);
        return TIME_W'(prod / 128'(pred_tick_rate)) + pred_base_time;
    endfunction

    function automatic arrival_t estimate_arrival(input logic [LEN_W-1:0] len,
                                                  input logic [TIME_W-1:0] cyc);
        arrival_t           r;
        logic               cal;
        logic [TIME_W-1:0]  est;
        logic [TIME_W-1:0]  now;
        logic [TIME_W-1:0]  old_anchor;
        logic [TIME_W-1:0]  elapsed;
        logic [TIME_W-1:0]  quot;
        logic [SUM_W-1:0]   sum;
        cal = (pred_items == CNT_W'(CALIBRATION_PERIOD));
        if (cal)
        begin
            est        = pred_anchor + TIME_W'(pred_bytes / pred_speed);
            now        = wall_time(cyc);
            old_anchor = pred_anchor;
            pred_items = CNT_W'(1);
            // estimate lagging: jump the anchor to true time
            if (est < now)
                pred_anchor = now;
            elapsed = now - old_anchor;
            if (elapsed != '0)
            begin
                quot       = TIME_W'(pred_bytes) / elapsed;
                pred_speed = (quot == '0) ? SPEED_W'(1) : quot[SPEED_W-1:0];
            end
            pred_bytes = '0;
        end
        else
        begin
            pred_items = pred_items + CNT_W'(1);
        end
        // saturating byte accumulation
        sum = SUM_W'(pred_bytes) + SUM_W'(len) + SUM_W'(EXTRA_BYTES);
        pred_bytes = sum[BYTE_W] ? '1 : sum[BYTE_W-1:0];
        r.stamp = pred_anchor + TIME_W'(pred_bytes / pred_speed);
        r.recal = cal;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!tx_random)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        if (r < 45)
            return LEN_W'($urandom_range(40, 1500));
        return LEN_W'($urandom);
    endfunction

    // Arbitrary counts, including values below base_cycles
    function automatic logic [TIME_W-1:0] wild_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return {$urandom, $urandom};
        if (r < 45)
            return pred_base_cycles - TIME_W'($urandom_range(1, 1000000));
        if (r < 55)
            return '1;
        if (r < 65)
            return '0;
        return pred_base_cycles + TIME_W'($urandom);
    endfunction

    // With tick rate equal to the unit rate, true time is exact, so the
    // calibrating count can be placed relative to the current anchor
    function automatic logic [TIME_W-1:0] steer_cycles();
        logic [TIME_W-1:0] aligned;
        int                r;
        aligned = pred_base_cycles + pred_anchor - pred_base_time;
        r = $urandom_range(0, 99);
        if (r < 20)
            return aligned;
        if (r < 40)
            return aligned + TIME_W'($urandom_range(1, 50));
        if (r < 55)
            return aligned + {$urandom, $urandom};
        if (r < 70)
            return aligned - TIME_W'($urandom_range(1, 1000));
        return aligned + TIME_W'(pred_bytes / pred_speed)
               + TIME_W'($urandom_range(0, 10)) - TIME_W'(5);
    endfunction

    // Offer one item and record its expected result on acceptance
    task automatic send_packet(input logic [LEN_W-1:0] len, input logic [TIME_W-1:0] cyc);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        packet_length <= len;
        cycle_count   <= cyc;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        pending_stamps.push_back(estimate_arrival(len, cyc));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_stamps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TICK_RATE:   pred_tick_rate = data[TICK_W-1:0];
            REG_BASE_CYCLES: pred_base_cycles = data;
            REG_BASE_TIME:
            begin
                pred_base_time = data;
                pred_anchor    = data;
            end
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_rates(input logic [TIME_W-1:0] tick, input logic [TIME_W-1:0] bcyc,
                             input logic [TIME_W-1:0] btime);
        wait_idle();
        write_reg(REG_TICK_RATE, tick);
        write_reg(REG_BASE_CYCLES, bcyc);
        write_reg(REG_BASE_TIME, btime);
        stream_cycles = bcyc + TIME_W'($urandom_range(0, 1000));
    endtask

    task automatic run_items(input int count, input cyc_style_t style);
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] cyc;
        for (int i = 0; i < count; i++)
        begin
            len = pick_length();
            // rough line-rate progression of the free-running counter
            stream_cycles += TIME_W'(((int'(len) + 24) * $urandom_range(4, 12)) / 100
                                     + $urandom_range(0, 3));
            if (style == STYLE_WILD)
                cyc = wild_cycles();
            else if (style == STYLE_STEER && pred_items == CNT_W'(CALIBRATION_PERIOD))
                cyc = steer_cycles();
            else
                cyc = stream_cycles;
            send_packet(len, cyc);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_extremes();
        tx_random = 1'b0;
        rx_random = 1'b0;
        // unmapped index must leave every register alone
        write_reg(REG_UNMAPPED, {$urandom, $urandom});
        send_packet('0, '0);
        send_packet('1, '1);
        send_packet('1, '0);
        send_packet('0, '1);
        send_packet(16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA);
        send_packet(16'h5555, 64'h5555_5555_5555_5555);
        for (int i = 0; i < 8; i++)
            send_packet('1, {$urandom, $urandom});
        send_packet(16'h0001, 64'h8000_0000_0000_0000);
        send_packet(16'h8000, 64'h0000_0000_0000_0001);
        wait_idle();
    endtask

    task automatic test_default_rate();
        set_rates(64'(TICK_RESET), '0, '0);
        run_items(100, STYLE_STREAM);
        tx_random = 1'b1;
        rx_random = 1'b1;
        run_items(200, STYLE_STREAM);
    endtask

    task automatic test_backpressure();
        tx_random = 1'b0;
        rx_hold   = 400;
        run_items(40, STYLE_STREAM);
        // sender holds off until every result is back
        wait_idle();
        tx_random = 1'b1;
    endtask

    task automatic test_exact_rate_calibration();
        set_rates(64'(UNITS_PER_SECOND), {$urandom, $urandom}, {$urandom, $urandom});
        run_items(250, STYLE_STEER);
        set_rates(64'(UNITS_PER_SECOND), '1, '0);
        run_items(250, STYLE_STEER);
    endtask

    task automatic test_min_tick_rate();
        set_rates(64'd1, '0, '0);
        run_items(120, STYLE_WILD);
    endtask

    task automatic test_max_tick_rate();
        // upper bits beyond the register width are dropped
        set_rates('1, '1, '1);
        run_items(120, STYLE_WILD);
    endtask

    task automatic test_zero_tick_rate();
        set_rates(64'h0000_0004_0000_0000, {$urandom, $urandom}, {$urandom, $urandom});
        run_items(50, STYLE_WILD);
        set_rates('0, '0, '1);
        run_items(50, STYLE_STREAM);
    endtask

    task automatic test_random_config();
        logic [TIME_W-1:0] tick;
        for (int round = 0; round < 3; round++)
        begin
            case (round)
                0:       tick = 64'($urandom_range(1, 1000));
                1:       tick = 64'($urandom_range(1000000, 2000000000));
                default: tick = {$urandom, $urandom};
            endcase
            set_rates(tick, {$urandom, $urandom}, {$urandom, $urandom});
            write_reg(REG_UNMAPPED, {$urandom, $urandom});
            run_items(50, STYLE_WILD);
            run_items(50, STYLE_STREAM);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: random ready with short and long stalls, plus holds
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int stall;
        int r;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else if (!rx_random)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    out_ready <= 1'b0;
                    stall = (r < 97) ? $urandom_range(0, 2) : $urandom_range(20, 60);
                end
            end
        end
    end

    // Compare each result with the oldest expectation
    always @(negedge clk)
    begin : result_check
        arrival_t want;
        if (out_valid && out_ready)
        begin
            if (pending_stamps.size() == 0)
            begin
                $error("unexpected result: timestamp %0h recalibrated %0b",
                       timestamp, recalibrated);
                errors++;
            end
            else
            begin
                want = pending_stamps.pop_front();
                if (timestamp !== want.stamp)
                begin
                    $error("timestamp: expected %0h, got %0h", want.stamp, timestamp);
                    errors++;
                end
                if (recalibrated !== want.recal)
                begin
                    $error("recalibrated: expected %0b, got %0b", want.recal, recalibrated);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stalled = 0;
        else
            stalled++;
        if (stalled >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_default_rate();
        test_backpressure();
        test_exact_rate_calibration();
        test_min_tick_rate();
        test_max_tick_rate();
        test_zero_tick_rate();
        test_random_config();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_stamps.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
